### sv/csp_pkg.sv
// shared types and constants for the connection slot pool with wait queue
// no dependencies; used by the interfaces and every module of the block

package csp_pkg;

    // fixed field widths of the transfer payloads
    localparam int KIND_W   = 1;
    localparam int REQ_W    = 8;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 2;

    // default sizing, handed to the top level parameters
    localparam int SLOT_COUNT_DEF      = 8;
    localparam int QUEUE_DEPTH_DEF     = 64;
    localparam int REQUESTER_COUNT_DEF = 256;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_OBTAIN  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

    // update command to the slot pool
    typedef struct packed {
        logic claim;     // mark lowest free slot busy, write its owner
        logic vacate;    // clear busy bit of the item's slot
        logic reassign;  // overwrite the owner of the item's slot
    } t_pool_cmd;

    // update command to the wait queue
    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_cmd;

    // wait queue status
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

endpackage

### sv/csp_if.sv
// valid/ready channel interfaces for request items and result items
// depends on csp_pkg for the field widths

interface csp_in_if import csp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [REQ_W-1:0]  requester;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, kind, requester, slot, input ready);
    modport sink   (input valid, kind, requester, slot, output ready);
endinterface

interface csp_out_if import csp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [REQ_W-1:0]    granted_requester;
    logic [SLOT_W-1:0]   granted_slot;
    logic [REQ_W-1:0]    released_owner;

    modport source (output valid, status, granted_requester, granted_slot,
                    released_owner, input ready);
    modport sink   (input valid, status, granted_requester, granted_slot,
                    released_owner, output ready);
endinterface

### sv/csp_slot_pool.sv
// slot pool: busy bits, busy count, lowest free slot search, owner memory
// depends on csp_pkg

module csp_slot_pool import csp_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int SW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [SW-1:0]        i_rd_slot,
    input  t_pool_cmd            i_cmd,
    input  logic [SW-1:0]        i_slot,
    input  logic [REQ_W-1:0]     i_owner,
    output logic                 o_full,
    output logic [SW-1:0]        o_free_idx,
    output logic                 o_slot_busy,
    output logic [REQ_W-1:0]     o_owner
);
    localparam int CW      = $clog2(SLOT_COUNT + 1);
    localparam int BUSY_PW = 1 << SW;

    logic [SLOT_COUNT-1:0] r_busy;
    logic [SLOT_COUNT-1:0] n_busy;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [BUSY_PW-1:0]    busy_pad;
    logic [REQ_W-1:0]      r_owner_mem [SLOT_COUNT];
    logic [REQ_W-1:0]      r_owner_rd;
    logic [SW-1:0]         wr_addr;

    // lowest free slot, priority encoder
    always_comb begin
        o_free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                o_free_idx = SW'(i);
            end
        end
    end

    assign busy_pad    = BUSY_PW'(r_busy);
    assign o_slot_busy = busy_pad[i_slot];
    assign o_full      = (r_count == CW'(SLOT_COUNT));
    assign o_owner     = r_owner_rd;

    // busy bits and count update
    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        if (i_cmd.claim) begin
            n_busy[o_free_idx] = 1'b1;
            n_count            = r_count + CW'(1);
        end else if (i_cmd.vacate) begin
            n_busy[i_slot] = 1'b0;
            n_count        = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
    end

    // owner memory, one write port and one registered read port
    assign wr_addr = i_cmd.claim ? o_free_idx : i_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.claim || i_cmd.reassign) begin
            r_owner_mem[wr_addr] <= i_owner;
        end
        if (i_rd_en) begin
            r_owner_rd <= r_owner_mem[i_rd_slot];
        end
    end

endmodule

### sv/csp_wait_queue.sv
// ring buffer wait queue of requester ids held in a synchronous memory
// depends on csp_pkg

module csp_wait_queue import csp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  t_queue_cmd        i_cmd,
    input  logic [REQ_W-1:0]  i_data,
    output t_queue_stat       o_stat,
    output logic [REQ_W-1:0]  o_head_data
);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [QW-1:0]    r_head;
    logic [QW-1:0]    r_tail;
    logic [LW-1:0]    r_level;
    logic [REQ_W-1:0] r_mem [QUEUE_DEPTH];
    logic [REQ_W-1:0] r_rd_data;

    function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
    endfunction

    assign o_stat.empty = (r_level == '0);
    assign o_stat.full  = (r_level == LW'(QUEUE_DEPTH));
    assign o_head_data  = r_rd_data;

    // pointer and level update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else if (i_cmd.push) begin
            r_tail  <= ring_next(r_tail);
            r_level <= r_level + LW'(1);
        end else if (i_cmd.pop) begin
            r_head  <= ring_next(r_head);
            r_level <= r_level - LW'(1);
        end
    end

    // storage, head entry read when an item is taken in
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

endmodule

### sv/connection_slot_pool_with_wait_queue_unit.sv
// top level: item sequencer and result register around slot pool and wait queue
// depends on csp_pkg, csp_if, csp_slot_pool, csp_wait_queue
// sequence: the item is captured and the memory reads issued at the transfer,
// then the result is decided from the read data, written back and loaded once
// the result register is free; input ready stays low until then, so only one
// item is in flight; a held result keeps the next item waiting
// reset: synchronous active low, empties the pool and the queue

module connection_slot_pool_with_wait_queue_unit import csp_pkg::*; #(
    parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
    parameter int REQUESTER_COUNT = REQUESTER_COUNT_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    csp_in_if.sink    i_in,
    csp_out_if.source o_out
);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                r_state;
    logic                n_state;
    logic                in_xfer;
    logic                can_load;

    logic [KIND_W-1:0]   r_kind;
    logic [REQ_W-1:0]    r_req;
    logic [SLOT_W-1:0]   r_slot;
    logic [SW-1:0]       slot_idx;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [REQ_W-1:0]    r_grant_req;
    logic [SLOT_W-1:0]   r_grant_slot;
    logic [REQ_W-1:0]    r_rel_owner;
    logic [STATUS_W-1:0] n_status;
    logic [REQ_W-1:0]    n_grant_req;
    logic [SLOT_W-1:0]   n_grant_slot;
    logic [REQ_W-1:0]    n_rel_owner;

    t_pool_cmd           pool_cmd;
    t_queue_cmd          queue_cmd;
    t_queue_stat         queue_stat;
    logic [REQ_W-1:0]    owner_wd;
    logic                pool_full;
    logic [SW-1:0]       free_idx;
    logic                slot_busy;
    logic [REQ_W-1:0]    pool_owner;
    logic [REQ_W-1:0]    queue_head;
    logic                req_bad;
    logic                slot_bad;

    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign can_load    = !r_out_valid || o_out.ready;
    assign slot_idx    = SW'(r_slot);

    csp_slot_pool #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_pool (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_xfer),
        .i_rd_slot   (SW'(i_in.slot)),
        .i_cmd       (pool_cmd),
        .i_slot      (slot_idx),
        .i_owner     (owner_wd),
        .o_full      (pool_full),
        .o_free_idx  (free_idx),
        .o_slot_busy (slot_busy),
        .o_owner     (pool_owner)
    );

    csp_wait_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_xfer),
        .i_cmd       (queue_cmd),
        .i_data      (r_req),
        .o_stat      (queue_stat),
        .o_head_data (queue_head)
    );

    // capture the item; memory reads are issued on the same edge
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= i_in.kind;
            r_req  <= i_in.requester;
            r_slot <= i_in.slot;
        end
    end

    assign req_bad  = (32'(r_req) >= 32'(REQUESTER_COUNT));
    assign slot_bad = (32'(r_slot) >= 32'(SLOT_COUNT)) || !slot_busy;

    // decide the result and the write back from the read data
    always_comb begin
        pool_cmd     = '0;
        queue_cmd    = '0;
        owner_wd     = r_req;
        n_status     = ST_REJECTED;
        n_grant_req  = '0;
        n_grant_slot = '0;
        n_rel_owner  = '0;
        if (r_state == S_EXEC && can_load) begin
            if (r_kind == KIND_OBTAIN) begin
                if (req_bad) begin
                    n_status = ST_REJECTED;
                end else if (!pool_full) begin
                    pool_cmd.claim = 1'b1;
                    n_status       = ST_GRANTED;
                    n_grant_req    = r_req;
                    n_grant_slot   = SLOT_W'(free_idx);
                end else if (!queue_stat.full) begin
                    queue_cmd.push = 1'b1;
                    n_status       = ST_QUEUED;
                    n_grant_req    = r_req;
                end
            end else if (!slot_bad) begin
                n_grant_slot = r_slot;
                n_rel_owner  = pool_owner;
                if (!queue_stat.empty) begin
                    // hand the slot straight to the head waiter
                    queue_cmd.pop     = 1'b1;
                    pool_cmd.reassign = 1'b1;
                    owner_wd          = queue_head;
                    n_status          = ST_GRANTED;
                    n_grant_req       = queue_head;
                end else begin
                    pool_cmd.vacate = 1'b1;
                    n_status        = ST_FREED;
                end
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC && can_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && can_load) begin
            r_status     <= n_status;
            r_grant_req  <= n_grant_req;
            r_grant_slot <= n_grant_slot;
            r_rel_owner  <= n_rel_owner;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_status;
    assign o_out.granted_requester = r_grant_req;
    assign o_out.granted_slot      = r_grant_slot;
    assign o_out.released_owner    = r_rel_owner;

endmodule

### sv/csp_checker.sv
// port level checks for the slot pool unit, attached by bind
// depends on csp_pkg and connection_slot_pool_with_wait_queue_unit

module csp_checker import csp_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [REQ_W-1:0]    i_granted_requester,
    input logic [SLOT_W-1:0]   i_granted_slot,
    input logic [REQ_W-1:0]    i_released_owner
);
    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    // one item at a time: no transfer in the cycle after a transfer
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in_ready)
        else $error("input ready high right after a transfer");

    // a fresh result rises only after its item transfer and the execute state that follows it
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_xfer, 2))
        else $error("result appeared without a matching item");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_granted_requester) && $stable(i_granted_slot)
            && $stable(i_released_owner))
        else $error("stalled result changed");

    // a rejected or queued result carries no slot or owner
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_REJECTED || i_status == ST_QUEUED)
            |-> i_granted_slot == '0 && i_released_owner == '0)
        else $error("rejected or queued result carries slot data");

endmodule

bind connection_slot_pool_with_wait_queue_unit csp_checker u_csp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_status            (o_out.status),
    .i_granted_requester (o_out.granted_requester),
    .i_granted_slot      (o_out.granted_slot),
    .i_released_owner    (o_out.released_owner)
);

### dv/tb_top.sv
// self-checking bench for the connection slot pool with wait queue unit
// depends on csp_pkg, csp_if and the unit's rtl; a built-in pool predictor checks every result
`timescale 1ns / 100ps

module tb_top;
    import csp_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int QDEPTH       = QUEUE_DEPTH_DEF;
    localparam int REQS         = REQUESTER_COUNT_DEF;
    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AFTER   = 320;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 8;

    // one result transfer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REQ_W-1:0]    requester;
        logic [SLOT_W-1:0]   slot;
        logic [REQ_W-1:0]    owner;
    } t_pool_outcome;

    // one directed request, with a typed-in outcome where it is obvious
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REQ_W-1:0]  requester;
        logic [SLOT_W-1:0] slot;
        logic              fixed;
        t_pool_outcome     outcome;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 20;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // release of an idle slot right after reset
        '{KIND_RELEASE, 8'h00, 3'd7, 1'b1, '{ST_REJECTED, 8'h00, 3'd0, 8'h00}},
        // first grants go to the lowest slots
        '{KIND_OBTAIN,  8'h00, 3'd0, 1'b1, '{ST_GRANTED, 8'h00, 3'd0, 8'h00}},
        '{KIND_OBTAIN,  8'hFF, 3'd0, 1'b1, '{ST_GRANTED, 8'hFF, 3'd1, 8'h00}},
        // fill the rest of the pool
        '{KIND_OBTAIN,  8'h01, 3'd0, 1'b0, '0},
        '{KIND_OBTAIN,  8'h80, 3'd0, 1'b0, '0},
        '{KIND_OBTAIN,  8'h7F, 3'd0, 1'b0, '0},
        '{KIND_OBTAIN,  8'hFE, 3'd0, 1'b0, '0},
        '{KIND_OBTAIN,  8'h55, 3'd0, 1'b0, '0},
        '{KIND_OBTAIN,  8'hAA, 3'd0, 1'b0, '0},
        // pool full: requesters wait, one of them already holds a slot
        '{KIND_OBTAIN,  8'h5A, 3'd0, 1'b0, '0},
        '{KIND_OBTAIN,  8'hA5, 3'd0, 1'b0, '0},
        '{KIND_OBTAIN,  8'h00, 3'd0, 1'b0, '0},
        // releases hand slots to waiters in order
        '{KIND_RELEASE, 8'h00, 3'd1, 1'b0, '0},
        '{KIND_RELEASE, 8'hFF, 3'd0, 1'b0, '0},
        '{KIND_RELEASE, 8'h00, 3'd7, 1'b0, '0},
        // queue empty: slots go free, a second release is refused
        '{KIND_RELEASE, 8'h00, 3'd3, 1'b0, '0},
        '{KIND_RELEASE, 8'h00, 3'd3, 1'b1, '{ST_REJECTED, 8'h00, 3'd0, 8'h00}},
        '{KIND_RELEASE, 8'h00, 3'd2, 1'b0, '0},
        '{KIND_OBTAIN,  8'h3C, 3'd0, 1'b0, '0},
        '{KIND_RELEASE, 8'h00, 3'd4, 1'b0, '0}
    };

    // share of obtains per random segment; the high ones drive the queue to full
    localparam int OBTAIN_BIAS [6] = '{97, 40, 10, 75, 97, 25};

    logic i_clk;
    logic i_rst_n;

    csp_in_if  req_ch ();
    csp_out_if res_ch ();

    connection_slot_pool_with_wait_queue_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // predictor state
    logic [SLOTS-1:0] busy_map = '0;
    logic [REQ_W-1:0] slot_holder [SLOTS];
    int               busy_slots = 0;
    logic [REQ_W-1:0] wait_line [$];

    t_pool_outcome awaited_outcomes [$];
    int            requests_sent  = 0;
    int            results_seen   = 0;
    int            mismatch_count = 0;
    int            src_idle_pct   = 0;
    int            snk_idle_pct   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // next state of the pool and the outcome for one accepted request
    function automatic t_pool_outcome predict_outcome(input logic [KIND_W-1:0] kind,
                                                      input logic [REQ_W-1:0] req,
                                                      input logic [SLOT_W-1:0] sl);
        t_pool_outcome res;
        int            idx;
        res = '{ST_REJECTED, '0, '0, '0};
        if (kind == KIND_OBTAIN) begin
            if (int'(req) >= REQS) begin
                // unknown requester stays rejected
            end else if (busy_slots < SLOTS) begin
                // lowest free slot wins
                idx = 0;
                while (busy_map[idx]) idx++;
                busy_map[idx]    = 1'b1;
                slot_holder[idx] = req;
                busy_slots++;
                res = '{ST_GRANTED, req, idx[SLOT_W-1:0], '0};
            end else if (wait_line.size() < QDEPTH) begin
                wait_line.push_back(req);
                res = '{ST_QUEUED, req, '0, '0};
            end
        end else if (int'(sl) < SLOTS && busy_map[sl]) begin
            res.owner = slot_holder[sl];
            res.slot  = sl;
            if (wait_line.size() > 0) begin
                // slot passes straight to the head waiter
                res.status       = ST_GRANTED;
                res.requester    = wait_line.pop_front();
                slot_holder[sl]  = res.requester;
            end else begin
                res.status   = ST_FREED;
                busy_map[sl] = 1'b0;
                busy_slots--;
            end
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // offer one request until it is taken, then record what should come back
    task automatic offer_request(input logic [KIND_W-1:0] kind,
                                 input logic [REQ_W-1:0] req,
                                 input logic [SLOT_W-1:0] sl,
                                 input logic use_fixed,
                                 input t_pool_outcome fixed_outcome);
        t_pool_outcome predicted;
        // idle pattern per phase of the run
        if (requests_sent < 270) begin
            src_idle_pct = 24;
            snk_idle_pct = 79;
        end else if (requests_sent < 520) begin
            src_idle_pct = 79;
            snk_idle_pct = 24;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.requester <= req;
        req_ch.slot      <= sl;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        requests_sent++;
        predicted = predict_outcome(kind, req, sl);
        awaited_outcomes.push_back(use_fixed ? fixed_outcome : predicted);
    endtask

    // stimulus: reset, directed table, then biased random segments
    initial begin : request_source
        int               bias;
        int               seg;
        int               seg_len;
        int               busy_list [$];
        logic [KIND_W-1:0] kd;
        logic [REQ_W-1:0]  rq;
        logic [SLOT_W-1:0] sl;
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_OBTAIN;
        req_ch.requester <= '0;
        req_ch.slot      <= '0;
        i_rst_n          <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            offer_request(DIRECTED[r].kind, DIRECTED[r].requester, DIRECTED[r].slot,
                          DIRECTED[r].fixed, DIRECTED[r].outcome);
        end

        seg = 0;
        while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            bias    = OBTAIN_BIAS[seg % 6];
            seg_len = (bias >= 90) ? $urandom_range(130, 90) : $urandom_range(80, 20);
            seg++;
            repeat (seg_len) begin
                kd = ($urandom_range(99) < bias) ? KIND_OBTAIN : KIND_RELEASE;
                rq = REQ_W'($urandom_range(255));
                sl = SLOT_W'($urandom_range(7));
                // most releases name a busy slot, the rest are random
                if (kd == KIND_RELEASE && $urandom_range(99) < 85) begin
                    busy_list.delete();
                    for (int i = 0; i < SLOTS; i++) begin
                        if (busy_map[i]) busy_list.push_back(i);
                    end
                    if (busy_list.size() > 0) begin
                        sl = SLOT_W'(busy_list[$urandom_range(busy_list.size() - 1)]);
                    end
                end
                offer_request(kd, rq, sl, 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        // drain outstanding results, then allow for stray ones
        while (awaited_outcomes.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off, and the checks
    initial begin : result_sink
        int            hold_left;
        bit            hold_done;
        t_pool_outcome want;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (awaited_outcomes.size() == 0) begin
                    $display("%0t: result transfer with none expected, status %0d", $time,
                             res_ch.status);
                    mismatch_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("status", want.status, res_ch.status);
                    check_field("granted_requester", want.requester, res_ch.granted_requester);
                    check_field("granted_slot", want.slot, res_ch.granted_slot);
                    check_field("released_owner", want.owner, res_ch.released_owner);
                end
                if (!hold_done && results_seen == HOLD_AFTER) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // run limit
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
